@@ hw/rtl/rbvi_pkg.sv @@
package rbvi_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int DT_BITS    = 16;
   localparam int UNIT_BITS  = 30;
   localparam int WORD_W     = 32;
   localparam int LIMIT_W    = 31;
   localparam int DT_W       = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_MASS      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRICTION  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY_X = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY_Y = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SIDE_LIM  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FALL_LIM  = 3'd5;

   localparam longint U31_MAX = 64'h7FFF_FFFF;
   localparam longint S32_MAX = 64'h7FFF_FFFF;

   // whole number in Q format, clipped to the register range
   function automatic longint scale_whole(input longint whole, input longint maxv);
      longint v;
      v = whole << FRAC_BITS;
      return (v > maxv) ? maxv : v;
   endfunction

   localparam logic [LIMIT_W-1:0] MASS_RESET     = LIMIT_W'(scale_whole(1, U31_MAX));
   localparam logic [LIMIT_W-1:0] FRICTION_RESET = LIMIT_W'(scale_whole(100, U31_MAX));
   localparam logic [WORD_W-1:0]  GRAV_X_RESET   = '0;
   localparam logic [WORD_W-1:0]  GRAV_Y_RESET   = WORD_W'(scale_whole(300, S32_MAX));
   localparam logic [LIMIT_W-1:0] SIDE_LIM_RESET = LIMIT_W'(scale_whole(200, U31_MAX));
   localparam logic [LIMIT_W-1:0] FALL_LIM_RESET = LIMIT_W'(scale_whole(1000, U31_MAX));

endpackage

@@ hw/rtl/rigid_body_velocity_integrator_2d.sv @@
// 2D velocity integrator, semi-implicit Euler in signed Q16.16 with dt in unsigned Q0.16.
// One req beat per frame tick carries the summed force, dt, the grounded flag and the
// current position; one rsp beat returns the new position and the new velocity, which the
// block also keeps as its state. A tick runs as a chain of steps through one registered
// 34x34 multiplier, a bit-serial 64/32 divider (up to ten quotients per tick, set by mass,
// gravity, which clamps apply and friction) and a 32-step integer square root per length
// with its squares (three per tick, a fourth for a moving body). req_stall stays high
// from an accepted beat until its result has been placed in the rsp register; a waiting
// rsp beat does not block the next req beat.
module rigid_body_velocity_integrator_2d (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [rbvi_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rbvi_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [rbvi_pkg::WORD_W-1:0]  req_force_x,
   input  logic signed [rbvi_pkg::WORD_W-1:0]  req_force_y,
   input  logic [rbvi_pkg::DT_W-1:0]           req_delta_time,
   input  logic                                req_grounded,
   input  logic signed [rbvi_pkg::WORD_W-1:0]  req_pos_x,
   input  logic signed [rbvi_pkg::WORD_W-1:0]  req_pos_y,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [rbvi_pkg::WORD_W-1:0]  rsp_new_pos_x,
   output logic signed [rbvi_pkg::WORD_W-1:0]  rsp_new_pos_y,
   output logic signed [rbvi_pkg::WORD_W-1:0]  rsp_vel_x,
   output logic signed [rbvi_pkg::WORD_W-1:0]  rsp_vel_y
);
   import rbvi_pkg::*;

   localparam int SW = 34;

   typedef enum logic [SW-1:0] {
      ST_IDLE    = 34'd1 << 0,
      ST_ACC_DIV = 34'd1 << 1,
      ST_ACC_MUL = 34'd1 << 2,
      ST_ACC_ADD = 34'd1 << 3,
      ST_LSQ     = 34'd1 << 4,
      ST_LSUM    = 34'd1 << 5,
      ST_WAIT    = 34'd1 << 6,
      ST_UDIV    = 34'd1 << 7,
      ST_USTORE  = 34'd1 << 8,
      ST_GRND    = 34'd1 << 9,
      ST_GDT     = 34'd1 << 10,
      ST_GADD    = 34'd1 << 11,
      ST_AX1     = 34'd1 << 12,
      ST_AX2     = 34'd1 << 13,
      ST_AX3     = 34'd1 << 14,
      ST_AX4     = 34'd1 << 15,
      ST_GSUB    = 34'd1 << 16,
      ST_SSUB    = 34'd1 << 17,
      ST_CCHK    = 34'd1 << 18,
      ST_CMUL    = 34'd1 << 19,
      ST_CDIV    = 34'd1 << 20,
      ST_CST     = 34'd1 << 21,
      ST_MERGE   = 34'd1 << 22,
      ST_FM1     = 34'd1 << 23,
      ST_FM2     = 34'd1 << 24,
      ST_FM3     = 34'd1 << 25,
      ST_FM4     = 34'd1 << 26,
      ST_FCHK    = 34'd1 << 27,
      ST_FMUL    = 34'd1 << 28,
      ST_FDIV    = 34'd1 << 29,
      ST_FST     = 34'd1 << 30,
      ST_POS     = 34'd1 << 31,
      ST_PADD    = 34'd1 << 32,
      ST_OUT     = 34'd1 << 33
   } state_type;

   typedef enum logic [1:0] {
      SRC_GRAV,
      SRC_PART,
      SRC_SIDE,
      SRC_VEL
   } src_type;

   localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
   localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > SAT_MAX) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < SAT_MIN) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'(v);
      end
      return r;
   endfunction

   // control
   state_type state_ff, state_in, ret_ff, ret_in;
   src_type   src_ff, src_in;
   logic      c_ff, c_in;
   logic      ax_pass_ff, ax_pass_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // configuration
   logic [LIMIT_W-1:0]       mass_ff, fric_ff, side_lim_ff, fall_lim_ff;
   logic signed [WORD_W-1:0] grav_ff [2];

   // tick data
   logic signed [WORD_W-1:0] vel_ff [2], vel_in [2];
   logic signed [WORD_W-1:0] force_ff [2], force_in [2];
   logic signed [WORD_W-1:0] pos_ff [2], pos_in [2];
   logic signed [WORD_W-1:0] npos_ff [2], npos_in [2];
   logic signed [WORD_W-1:0] u_ff [2], u_in [2];
   logic signed [SW-1:0]     p_ff [2], p_in [2];
   logic signed [WORD_W-1:0] s_ff [2], s_in [2];
   logic signed [WORD_W-1:0] out_pos_ff [2], out_pos_in [2];
   logic signed [WORD_W-1:0] out_vel_ff [2], out_vel_in [2];
   logic [DT_W-1:0]          dt_ff, dt_in;
   logic                     gnd_ff, gnd_in;
   logic signed [63:0]       acc_ff, acc_in;
   logic signed [SW-1:0]     d_ff, d_in;
   logic [WORD_W-1:0]        f_ff, f_in;

   // multiplier
   logic signed [SW-1:0]     mul_a, mul_b;
   logic signed [2*SW-1:0]   mul_full;
   logic signed [63:0]       mul_p_ff;

   // divider
   logic                     div_go;
   logic signed [63:0]       div_num;
   logic [WORD_W-1:0]        div_den;
   logic [6:0]               div_cnt_ff;
   logic [WORD_W-1:0]        div_rem_ff, div_den_ff;
   logic [63:0]              div_quo_ff;
   logic                     div_neg_ff;
   logic [WORD_W:0]          div_rem_sh;
   logic                     div_ge;
   logic signed [63:0]       div_q;

   // square root
   logic                     sq_go;
   logic [63:0]              sq_num;
   logic [63:0]              sq_n_ff, sq_r_ff, sq_bit_ff, sq_trial;
   logic [WORD_W-1:0]        len;

   logic signed [SW-1:0]     lvec, cvec;
   logic [LIMIT_W-1:0]       limit;
   logic signed [WORD_W-1:0] merge [2];
   logic [63:0]              fm_raw;

   assign mul_full   = mul_a * mul_b;
   assign div_rem_sh = {div_rem_ff, div_quo_ff[63]};
   assign div_ge     = div_rem_sh >= {1'b0, div_den_ff};
   assign div_q      = div_neg_ff ? -$signed(div_quo_ff) : $signed(div_quo_ff);
   assign sq_trial   = sq_r_ff + sq_bit_ff;
   assign len        = sq_r_ff[WORD_W-1:0];
   assign fm_raw     = $unsigned(mul_p_ff) >> FRAC_BITS;

   always_comb begin
      unique case (src_ff)
         SRC_GRAV: lvec = SW'(grav_ff[c_ff]);
         SRC_PART: lvec = p_ff[c_ff];
         SRC_SIDE: lvec = SW'(s_ff[c_ff]);
         SRC_VEL:  lvec = SW'(vel_ff[c_ff]);
         default:  lvec = '0;
      endcase
   end

   assign cvec  = (src_ff == SRC_SIDE) ? SW'(s_ff[c_ff]) : p_ff[c_ff];
   assign limit = (src_ff == SRC_SIDE) ? side_lim_ff : fall_lim_ff;
   assign merge[0] = sat32(66'(p_ff[0]) + 66'(s_ff[0]));
   assign merge[1] = sat32(66'(p_ff[1]) + 66'(s_ff[1]));

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      src_in       = src_ff;
      c_in         = c_ff;
      ax_pass_in   = ax_pass_ff;
      rsp_valid_in = rsp_valid_ff;
      vel_in       = vel_ff;
      force_in     = force_ff;
      pos_in       = pos_ff;
      npos_in      = npos_ff;
      u_in         = u_ff;
      p_in         = p_ff;
      s_in         = s_ff;
      out_pos_in   = out_pos_ff;
      out_vel_in   = out_vel_ff;
      dt_in        = dt_ff;
      gnd_in       = gnd_ff;
      acc_in       = acc_ff;
      d_in         = d_ff;
      f_in         = f_ff;
      mul_a        = '0;
      mul_b        = '0;
      div_go       = 1'b0;
      div_num      = '0;
      div_den      = '0;
      sq_go        = 1'b0;
      sq_num       = '0;

      // drop the rsp beat once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               force_in[0] = req_force_x;
               force_in[1] = req_force_y;
               pos_in[0]   = req_pos_x;
               pos_in[1]   = req_pos_y;
               dt_in       = req_delta_time;
               gnd_in      = req_grounded;
               c_in        = 1'b0;
               state_in    = ST_ACC_DIV;
            end
         end
         ST_ACC_DIV: begin
            if (mass_ff == '0) begin
               c_in     = 1'b0;
               src_in   = SRC_GRAV;
               ret_in   = ST_UDIV;
               state_in = ST_LSQ;
            end else begin
               div_go   = 1'b1;
               div_num  = 64'(force_ff[c_ff]) <<< FRAC_BITS;
               div_den  = {1'b0, mass_ff};
               ret_in   = ST_ACC_MUL;
               state_in = ST_WAIT;
            end
         end
         ST_ACC_MUL: begin
            mul_a    = SW'(sat32(66'(div_q)));
            mul_b    = SW'($signed({1'b0, dt_ff}));
            state_in = ST_ACC_ADD;
         end
         ST_ACC_ADD: begin
            vel_in[c_ff] = sat32(66'(vel_ff[c_ff]) + 66'(mul_p_ff >>> DT_BITS));
            if (!c_ff) begin
               c_in     = 1'b1;
               state_in = ST_ACC_DIV;
            end else begin
               c_in     = 1'b0;
               src_in   = SRC_GRAV;
               ret_in   = ST_UDIV;
               state_in = ST_LSQ;
            end
         end
         ST_LSQ: begin
            mul_a    = lvec;
            mul_b    = lvec;
            state_in = ST_LSUM;
         end
         ST_LSUM: begin
            if (!c_ff) begin
               acc_in   = mul_p_ff;
               c_in     = 1'b1;
               state_in = ST_LSQ;
            end else begin
               c_in     = 1'b0;
               sq_go    = 1'b1;
               sq_num   = $unsigned(acc_ff + mul_p_ff);
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (div_cnt_ff == '0 && sq_bit_ff == '0) begin
               state_in = ret_ff;
            end
         end
         ST_UDIV: begin
            if (len == '0) begin
               u_in[0]  = '0;
               u_in[1]  = '0;
               c_in     = 1'b0;
               state_in = ST_GRND;
            end else begin
               div_go   = 1'b1;
               div_num  = 64'(grav_ff[c_ff]) <<< UNIT_BITS;
               div_den  = len;
               ret_in   = ST_USTORE;
               state_in = ST_WAIT;
            end
         end
         ST_USTORE: begin
            u_in[c_ff] = div_q[WORD_W-1:0];
            if (!c_ff) begin
               c_in     = 1'b1;
               state_in = ST_UDIV;
            end else begin
               c_in     = 1'b0;
               state_in = ST_GRND;
            end
         end
         ST_GRND: begin
            c_in = 1'b0;
            if (gnd_ff) begin
               ax_pass_in = 1'b0;
               state_in   = ST_AX1;
            end else begin
               state_in   = ST_GDT;
            end
         end
         ST_GDT: begin
            mul_a    = SW'(grav_ff[c_ff]);
            mul_b    = SW'($signed({1'b0, dt_ff}));
            state_in = ST_GADD;
         end
         ST_GADD: begin
            vel_in[c_ff] = sat32(66'(vel_ff[c_ff]) + 66'(mul_p_ff >>> DT_BITS));
            if (!c_ff) begin
               c_in     = 1'b1;
               state_in = ST_GDT;
            end else begin
               c_in       = 1'b0;
               ax_pass_in = 1'b1;
               state_in   = ST_AX1;
            end
         end
         ST_AX1: begin
            mul_a    = SW'(vel_ff[c_ff]);
            mul_b    = SW'(u_ff[c_ff]);
            state_in = ST_AX2;
         end
         ST_AX2: begin
            if (!c_ff) begin
               acc_in   = mul_p_ff;
               c_in     = 1'b1;
               state_in = ST_AX1;
            end else begin
               d_in     = SW'((acc_ff + mul_p_ff) >>> UNIT_BITS);
               c_in     = 1'b0;
               state_in = ST_AX3;
            end
         end
         ST_AX3: begin
            mul_a    = d_ff;
            mul_b    = SW'(u_ff[c_ff]);
            state_in = ST_AX4;
         end
         ST_AX4: begin
            p_in[c_ff] = SW'(mul_p_ff >>> UNIT_BITS);
            if (!c_ff) begin
               c_in     = 1'b1;
               state_in = ST_AX3;
            end else begin
               c_in     = 1'b0;
               state_in = ax_pass_ff ? ST_SSUB : ST_GSUB;
            end
         end
         ST_GSUB: begin
            vel_in[0]  = sat32(66'(vel_ff[0]) - 66'(p_ff[0]));
            vel_in[1]  = sat32(66'(vel_ff[1]) - 66'(p_ff[1]));
            ax_pass_in = 1'b1;
            c_in       = 1'b0;
            state_in   = ST_AX1;
         end
         ST_SSUB: begin
            s_in[0]  = sat32(66'(vel_ff[0]) - 66'(p_ff[0]));
            s_in[1]  = sat32(66'(vel_ff[1]) - 66'(p_ff[1]));
            p_in[0]  = SW'(sat32(66'(p_ff[0])));
            p_in[1]  = SW'(sat32(66'(p_ff[1])));
            src_in   = SRC_PART;
            ret_in   = ST_CCHK;
            c_in     = 1'b0;
            state_in = ST_LSQ;
         end
         ST_CCHK: begin
            c_in = 1'b0;
            if ({1'b0, limit} < len) begin
               state_in = ST_CMUL;
            end else if (src_ff == SRC_PART) begin
               src_in   = SRC_SIDE;
               state_in = ST_LSQ;
            end else begin
               state_in = ST_MERGE;
            end
         end
         ST_CMUL: begin
            mul_a    = cvec;
            mul_b    = SW'($signed({1'b0, limit}));
            state_in = ST_CDIV;
         end
         ST_CDIV: begin
            div_go   = 1'b1;
            div_num  = mul_p_ff;
            div_den  = len;
            ret_in   = ST_CST;
            state_in = ST_WAIT;
         end
         ST_CST: begin
            if (src_ff == SRC_SIDE) begin
               s_in[c_ff] = div_q[WORD_W-1:0];
            end else begin
               p_in[c_ff] = SW'(div_q);
            end
            if (!c_ff) begin
               c_in     = 1'b1;
               state_in = ST_CMUL;
            end else begin
               c_in = 1'b0;
               if (src_ff == SRC_PART) begin
                  src_in   = SRC_SIDE;
                  ret_in   = ST_CCHK;
                  state_in = ST_LSQ;
               end else begin
                  state_in = ST_MERGE;
               end
            end
         end
         ST_MERGE: begin
            vel_in[0] = merge[0];
            vel_in[1] = merge[1];
            c_in      = 1'b0;
            state_in  = (merge[0] != '0 || merge[1] != '0) ? ST_FM1 : ST_POS;
         end
         ST_FM1: begin
            mul_a    = SW'($signed({1'b0, fric_ff}));
            mul_b    = SW'($signed({1'b0, mass_ff}));
            state_in = ST_FM2;
         end
         ST_FM2: begin
            f_in     = (fm_raw > 64'hFFFF_FFFF) ? '1 : fm_raw[WORD_W-1:0];
            state_in = ST_FM3;
         end
         ST_FM3: begin
            mul_a    = SW'($signed({1'b0, f_ff}));
            mul_b    = SW'($signed({1'b0, dt_ff}));
            state_in = ST_FM4;
         end
         ST_FM4: begin
            f_in     = 32'($unsigned(mul_p_ff) >> DT_BITS);
            src_in   = SRC_VEL;
            ret_in   = ST_FCHK;
            c_in     = 1'b0;
            state_in = ST_LSQ;
         end
         ST_FCHK: begin
            c_in = 1'b0;
            if (len < f_ff) begin
               vel_in[0] = '0;
               vel_in[1] = '0;
               state_in  = ST_POS;
            end else if (len != '0) begin
               state_in  = ST_FMUL;
            end else begin
               state_in  = ST_POS;
            end
         end
         ST_FMUL: begin
            mul_a    = SW'(vel_ff[c_ff]);
            mul_b    = SW'($signed({1'b0, f_ff}));
            state_in = ST_FDIV;
         end
         ST_FDIV: begin
            div_go   = 1'b1;
            div_num  = mul_p_ff;
            div_den  = len;
            ret_in   = ST_FST;
            state_in = ST_WAIT;
         end
         ST_FST: begin
            vel_in[c_ff] = vel_ff[c_ff] - $signed(div_q[WORD_W-1:0]);
            if (!c_ff) begin
               c_in     = 1'b1;
               state_in = ST_FMUL;
            end else begin
               c_in     = 1'b0;
               state_in = ST_POS;
            end
         end
         ST_POS: begin
            mul_a    = SW'(vel_ff[c_ff]);
            mul_b    = SW'($signed({1'b0, dt_ff}));
            state_in = ST_PADD;
         end
         ST_PADD: begin
            npos_in[c_ff] = sat32(66'(pos_ff[c_ff]) + 66'(mul_p_ff >>> DT_BITS));
            if (!c_ff) begin
               c_in     = 1'b1;
               state_in = ST_POS;
            end else begin
               c_in     = 1'b0;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold until the rsp register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               out_pos_in   = npos_ff;
               out_vel_in   = vel_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         src_ff       <= SRC_GRAV;
         c_ff         <= 1'b0;
         ax_pass_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vel_ff[0]    <= '0;
         vel_ff[1]    <= '0;
         mass_ff      <= MASS_RESET;
         fric_ff      <= FRICTION_RESET;
         grav_ff[0]   <= GRAV_X_RESET;
         grav_ff[1]   <= GRAV_Y_RESET;
         side_lim_ff  <= SIDE_LIM_RESET;
         fall_lim_ff  <= FALL_LIM_RESET;
         div_cnt_ff   <= '0;
         sq_bit_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         src_ff       <= src_in;
         c_ff         <= c_in;
         ax_pass_ff   <= ax_pass_in;
         rsp_valid_ff <= rsp_valid_in;
         vel_ff       <= vel_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_MASS:      mass_ff     <= csr_wdata[LIMIT_W-1:0];
               CSR_FRICTION:  fric_ff     <= csr_wdata[LIMIT_W-1:0];
               CSR_GRAVITY_X: grav_ff[0]  <= csr_wdata;
               CSR_GRAVITY_Y: grav_ff[1]  <= csr_wdata;
               CSR_SIDE_LIM:  side_lim_ff <= csr_wdata[LIMIT_W-1:0];
               CSR_FALL_LIM:  fall_lim_ff <= csr_wdata[LIMIT_W-1:0];
               default: begin
               end
            endcase
         end
         if (div_go) begin
            div_cnt_ff <= 7'd64;
         end else if (div_cnt_ff != '0) begin
            div_cnt_ff <= div_cnt_ff - 7'd1;
         end
         if (sq_go) begin
            sq_bit_ff <= 64'd1 << 62;
         end else if (sq_bit_ff != '0) begin
            sq_bit_ff <= sq_bit_ff >> 2;
         end
      end
   end

   always_ff @(posedge clock) begin
      force_ff   <= force_in;
      pos_ff     <= pos_in;
      npos_ff    <= npos_in;
      u_ff       <= u_in;
      p_ff       <= p_in;
      s_ff       <= s_in;
      out_pos_ff <= out_pos_in;
      out_vel_ff <= out_vel_in;
      dt_ff      <= dt_in;
      gnd_ff     <= gnd_in;
      acc_ff     <= acc_in;
      d_ff       <= d_in;
      f_ff       <= f_in;
      mul_p_ff   <= mul_full[63:0];

      // restoring divide on magnitudes, sign applied at the end
      if (div_go) begin
         div_neg_ff <= div_num < 0;
         div_quo_ff <= (div_num < 0) ? $unsigned(-div_num) : $unsigned(div_num);
         div_rem_ff <= '0;
         div_den_ff <= div_den;
      end else if (div_cnt_ff != '0) begin
         div_rem_ff <= div_ge ? WORD_W'(div_rem_sh - {1'b0, div_den_ff})
                              : div_rem_sh[WORD_W-1:0];
         div_quo_ff <= {div_quo_ff[62:0], div_ge};
      end

      if (sq_go) begin
         sq_n_ff <= sq_num;
         sq_r_ff <= '0;
      end else if (sq_bit_ff != '0) begin
         if (sq_n_ff >= sq_trial) begin
            sq_n_ff <= sq_n_ff - sq_trial;
            sq_r_ff <= (sq_r_ff >> 1) + sq_bit_ff;
         end else begin
            sq_r_ff <= sq_r_ff >> 1;
         end
      end
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_new_pos_x = out_pos_ff[0];
   assign rsp_new_pos_y = out_pos_ff[1];
   assign rsp_vel_x     = out_vel_ff[0];
   assign rsp_vel_y     = out_vel_ff[1];

endmodule

@@ hw/rtl/rbvi_checker.sv @@
module rbvi_sva (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall
);

   // a waiting rsp beat stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   // an accepted req beat keeps the block busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("req taken again right after a beat");

   // no result is raised in the cycle after a req beat
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("rsp raised too early");

   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid && !req_stall)
      else $error("not idle after reset");

endmodule

bind rigid_body_velocity_integrator_2d rbvi_sva u_rbvi_sva (.*);

@@ dv/rbvi_checker.sv @@
`timescale 1ns / 1ps

module rbvi_checker
   import rbvi_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic signed [WORD_W-1:0]    req_force_x,
   input  logic signed [WORD_W-1:0]    req_force_y,
   input  logic [DT_W-1:0]             req_delta_time,
   input  logic                        req_grounded,
   input  logic signed [WORD_W-1:0]    req_pos_x,
   input  logic signed [WORD_W-1:0]    req_pos_y,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic signed [WORD_W-1:0]    rsp_new_pos_x,
   input  logic signed [WORD_W-1:0]    rsp_new_pos_y,
   input  logic signed [WORD_W-1:0]    rsp_vel_x,
   input  logic signed [WORD_W-1:0]    rsp_vel_y,
   output int                          fail_count,
   output int                          ticks_in_flight
);

   typedef struct packed {
      logic signed [WORD_W-1:0] pos_x;
      logic signed [WORD_W-1:0] pos_y;
      logic signed [WORD_W-1:0] vel_x;
      logic signed [WORD_W-1:0] vel_y;
   } motion_t;

   motion_t motion_q[$];

   longint unsigned mass_r, friction_r, side_lim_r, fall_lim_r;
   longint          grav_x_r, grav_y_r, body_vx, body_vy;

   function automatic longint sat_word(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint unsigned root64(input longint unsigned n);
      longint unsigned r = 0;
      longint unsigned b = 64'h4000_0000_0000_0000;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint unsigned mag(input longint x, input longint y);
      return root64(longint'(x * x) + longint'(y * y));
   endfunction

   function automatic void clip_len(inout longint x, inout longint y,
                                    input longint unsigned lim);
      longint unsigned len;
      len = mag(x, y);
      if (lim < len) begin
         x = x * longint'(lim) / longint'(len);
         y = y * longint'(lim) / longint'(len);
      end
   endfunction

   // component of v along the unit vector u (30 fraction bits)
   function automatic void along_axis(input longint vx, input longint vy,
                                      input longint ux, input longint uy,
                                      output longint px, output longint py);
      longint d;
      d  = (vx * ux + vy * uy) >>> UNIT_BITS;
      px = (d * ux) >>> UNIT_BITS;
      py = (d * uy) >>> UNIT_BITS;
   endfunction

   function automatic motion_t integrate_tick(input longint fx, input longint fy,
                                              input longint dt, input bit on_ground,
                                              input longint posx, input longint posy);
      longint vx, vy, ux, uy, px, py, sx, sy, ax, ay;
      longint unsigned glen, fm, f, len;
      motion_t res;
      vx = body_vx;
      vy = body_vy;
      ux = 0;
      uy = 0;
      if (mass_r != 0) begin
         ax = sat_word((fx <<< FRAC_BITS) / longint'(mass_r));
         ay = sat_word((fy <<< FRAC_BITS) / longint'(mass_r));
         vx = sat_word(vx + ((ax * dt) >>> DT_BITS));
         vy = sat_word(vy + ((ay * dt) >>> DT_BITS));
      end
      glen = mag(grav_x_r, grav_y_r);
      if (glen != 0) begin
         ux = (grav_x_r <<< UNIT_BITS) / longint'(glen);
         uy = (grav_y_r <<< UNIT_BITS) / longint'(glen);
      end
      if (on_ground) begin
         along_axis(vx, vy, ux, uy, px, py);
         vx = sat_word(vx - px);
         vy = sat_word(vy - py);
      end else begin
         vx = sat_word(vx + ((grav_x_r * dt) >>> DT_BITS));
         vy = sat_word(vy + ((grav_y_r * dt) >>> DT_BITS));
      end
      along_axis(vx, vy, ux, uy, px, py);
      sx = sat_word(vx - px);
      sy = sat_word(vy - py);
      px = sat_word(px);
      py = sat_word(py);
      clip_len(px, py, fall_lim_r);
      clip_len(sx, sy, side_lim_r);
      vx = sat_word(px + sx);
      vy = sat_word(py + sy);
      // friction stops the body instead of reversing it
      if (vx != 0 || vy != 0) begin
         fm = (friction_r * mass_r) >> FRAC_BITS;
         if (fm > 64'hFFFF_FFFF) fm = 64'hFFFF_FFFF;
         f   = (fm * longint'(dt)) >> DT_BITS;
         len = mag(vx, vy);
         if (len < f) begin
            vx = 0;
            vy = 0;
         end else if (len != 0) begin
            vx = vx - vx * longint'(f) / longint'(len);
            vy = vy - vy * longint'(f) / longint'(len);
         end
      end
      body_vx   = vx;
      body_vy   = vy;
      res.pos_x = WORD_W'(sat_word(posx + ((vx * dt) >>> DT_BITS)));
      res.pos_y = WORD_W'(sat_word(posy + ((vy * dt) >>> DT_BITS)));
      res.vel_x = WORD_W'(vx);
      res.vel_y = WORD_W'(vy);
      return res;
   endfunction

   always @(posedge clock) begin
      motion_t want;
      if (reset) begin
         mass_r          = MASS_RESET;
         friction_r      = FRICTION_RESET;
         grav_x_r        = longint'(signed'(GRAV_X_RESET));
         grav_y_r        = longint'(signed'(GRAV_Y_RESET));
         side_lim_r      = SIDE_LIM_RESET;
         fall_lim_r      = FALL_LIM_RESET;
         body_vx         = 0;
         body_vy         = 0;
         fail_count      = 0;
         ticks_in_flight = 0;
         motion_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MASS:      mass_r     = csr_wdata[LIMIT_W-1:0];
               CSR_FRICTION:  friction_r = csr_wdata[LIMIT_W-1:0];
               CSR_GRAVITY_X: grav_x_r   = longint'(signed'(csr_wdata));
               CSR_GRAVITY_Y: grav_y_r   = longint'(signed'(csr_wdata));
               CSR_SIDE_LIM:  side_lim_r = csr_wdata[LIMIT_W-1:0];
               CSR_FALL_LIM:  fall_lim_r = csr_wdata[LIMIT_W-1:0];
               default: ;
            endcase
         end
         // retire the result beat before queuing a new tick
         if (rsp_valid && !rsp_stall) begin
            if (motion_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("rbvi_checker: result beat with no tick pending");
            end else begin
               want = motion_q.pop_front();
               if (want.pos_x !== rsp_new_pos_x || want.pos_y !== rsp_new_pos_y ||
                   want.vel_x !== rsp_vel_x || want.vel_y !== rsp_vel_y) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("rbvi_checker: mismatch exp pos %0d,%0d vel %0d,%0d got pos %0d,%0d vel %0d,%0d",
                              want.pos_x, want.pos_y, want.vel_x, want.vel_y,
                              rsp_new_pos_x, rsp_new_pos_y, rsp_vel_x, rsp_vel_y);
               end
            end
         end
         if (req_valid && !req_stall)
            motion_q.push_back(integrate_tick(req_force_x, req_force_y, req_delta_time,
                                              req_grounded, req_pos_x, req_pos_y));
         ticks_in_flight = motion_q.size();
      end
   end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import rbvi_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;
   localparam int                   WATCHDOG    = 8000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [WORD_W-1:0] req_force_x = '0, req_force_y = '0;
   logic signed [WORD_W-1:0] req_pos_x = '0, req_pos_y = '0;
   logic [DT_W-1:0] req_delta_time = '0;
   logic req_grounded = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   logic signed [WORD_W-1:0] rsp_new_pos_x, rsp_new_pos_y, rsp_vel_x, rsp_vel_y;

   int fail_count, ticks_in_flight;
   int cycle_count = 0;
   bit no_gaps = 0;
   bit long_hold = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   rigid_body_velocity_integrator_2d dut (.*);
   rbvi_checker checker_i (.*);

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= WATCHDOG) begin
         $display("tb: failure");
         $finish;
      end
   end

   // result side: random stall before each beat outside the no-gap phase, plus one long hold-off
   initial begin
      int k;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            k = 4000;
            long_hold = 0;
         end else begin
            k = no_gaps ? 0 : $urandom_range(0, 4);
         end
         if (k != 0) begin
            rsp_stall <= 1'b1;
            repeat (k) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_tick(input logic [31:0] fx, input logic [31:0] fy,
                            input logic [15:0] dt, input logic gnd,
                            input logic [31:0] px, input logic [31:0] py);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_force_x    <= fx;
      req_force_y    <= fy;
      req_delta_time <= dt;
      req_grounded   <= gnd;
      req_pos_x      <= px;
      req_pos_y      <= py;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      csr_wr_en <= 1'b0;
      @(posedge clock);
      while (ticks_in_flight != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 6))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return '0;
         3, 4:    return 32'($signed($urandom_range(0, 2 ** 22)) - 2 ** 21);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_limit();
      case ($urandom_range(0, 4))
         0:       return 32'h7FFF_FFFF;
         1:       return '0;
         2:       return $urandom_range(0, 32'h0FFF_FFFF);
         default: return $urandom_range(32'h0001_0000, 32'h0400_0000);
      endcase
   endfunction

   function automatic logic [15:0] pick_dt();
      case ($urandom_range(0, 4))
         0:       return 16'hFFFF;
         1:       return '0;
         2:       return 16'd1092;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: extremes of every field
      send_tick(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000);
      send_tick(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
      send_tick('0, '0, '0, 1'b0, '0, '0);
      send_tick('0, '0, 16'd1092, 1'b1, 32'h0001_0000, 32'h0001_0000);
      send_tick(32'h0100_0000, '0, 16'd1092, 1'b1, '0, '0);
      send_tick('0, 32'h8000_0000, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_tick('0, '0, 16'hFFFF, 1'b0, 32'h7FFF_0000, 32'h7FFF_0000);
      drain();

      // zero mass, zero gravity, unused register indexes
      csr_write(CSR_MASS, '0);
      csr_write(CSR_GRAVITY_X, '0);
      csr_write(CSR_GRAVITY_Y, '0);
      csr_write(CSR_SPARE_A, 32'hFFFF_FFFF);
      csr_write(CSR_SPARE_B, 32'h1234_5678);
      drain();
      send_tick(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 1'b0, '0, '0);
      send_tick('0, '0, 16'd1092, 1'b1, 32'h0000_1000, 32'hFFFF_0000);
      drain();

      // max everything, friction zero, huge gravity
      csr_write(CSR_MASS, 32'hFFFF_FFFF);
      csr_write(CSR_FRICTION, '0);
      csr_write(CSR_GRAVITY_X, 32'h8000_0000);
      csr_write(CSR_GRAVITY_Y, 32'h7FFF_FFFF);
      csr_write(CSR_SIDE_LIM, 32'hFFFF_FFFF);
      csr_write(CSR_FALL_LIM, 32'hFFFF_FFFF);
      drain();
      send_tick(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 1'b0, '0, '0);
      send_tick(32'h8000_0000, 32'h8000_0000, 16'hFFFF, 1'b0, '0, '0);
      send_tick('0, '0, 16'hFFFF, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000);
      drain();

      // tiny mass, max friction, zero limits
      csr_write(CSR_MASS, 32'd1);
      csr_write(CSR_FRICTION, 32'h7FFF_FFFF);
      csr_write(CSR_SIDE_LIM, '0);
      csr_write(CSR_FALL_LIM, '0);
      drain();
      send_tick(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd1, 1'b0, '0, '0);
      send_tick(32'h0001_0000, 32'hFFFF_0000, 16'hFFFF, 1'b1, '0, '0);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         csr_write(CSR_MASS, ($urandom_range(0, 3) == 0) ? pick_limit() :
                             $urandom_range(32'h0000_4000, 32'h0010_0000));
         csr_write(CSR_FRICTION, ($urandom_range(0, 2) == 0) ? pick_limit() :
                                 $urandom_range(0, 32'h0100_0000));
         csr_write(CSR_GRAVITY_X, ($urandom_range(0, 1) == 0) ? '0 : pick_word());
         csr_write(CSR_GRAVITY_Y, pick_word());
         csr_write(CSR_SIDE_LIM, pick_limit());
         csr_write(CSR_FALL_LIM, pick_limit());
         drain();
         no_gaps = (ph == 3);
         for (int n = 0; n < 190; n++) begin
            if (ph == 2 && n == 40) long_hold = 1;
            send_tick(pick_word(), pick_word(), pick_dt(), 1'($urandom_range(0, 1)),
                      pick_word(), pick_word());
         end
         no_gaps = 0;
         drain();
      end

      repeat (1000) @(posedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
